>>> hdl/phdg_pkg.sv
// ---------------------------------------------------------------------------
// phdg_pkg
// Shared types and constants for the path hash deny gate.
// ---------------------------------------------------------------------------
package phdg_pkg;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_PATH  = 2'd1;
    localparam logic [1:0] KIND_EXIT  = 2'd2;
    localparam logic [1:0] KIND_CHECK = 2'd3;

    localparam logic [63:0] FNV_BASIS    = 64'hCBF29CE484222325;
    localparam logic [12:0] DENY_VERDICT = 13'h1FF3;

    typedef struct packed {
        logic cap;
        logic deny_wr;
        logic hash_xor;
        logic hash_mul;
        logic scan_clr;
        logic ptr_inc;
        logic dcmp;
        logic pcmp;
        logic pend_wr;
        logic clr_wr;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       byte_zero;
        logic       prior_zero;
        logic       slot_ok;
        logic       count_full;
        logic       last_deny;
        logic       last_pend;
        logic       last_clr;
        logic       hit;
        logic       found;
        logic       free;
        logic       out_busy;
    } t_sts;

    // multiply by the FNV prime 2^40 + 0x1B3, modulo 2^64
    function automatic logic [63:0] fnv_mul(input logic [63:0] v);
        fnv_mul = (v << 40) + (v << 8) + (v << 7) + (v << 5) + (v << 4) + (v << 1) + v;
    endfunction

endpackage

>>> hdl/phdg_ram.sv
// ---------------------------------------------------------------------------
// phdg_ram
// Single-port RAM with registered read.
// ---------------------------------------------------------------------------
module phdg_ram #(
    parameter int WIDTH = 65,
    parameter int DEPTH = 64
) (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                    i_wdata,
    output logic [WIDTH-1:0]                    o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> hdl/phdg_ctrl.sv
// ---------------------------------------------------------------------------
// phdg_ctrl
// Sequencer: clear pass, dispatch by kind, table scans, result hand-off.
// ---------------------------------------------------------------------------
module phdg_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  phdg_pkg::t_sts  i_sts,
    output phdg_pkg::t_cmd  o_cmd
);
    import phdg_pkg::*;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_DISP = 4'd2;
    localparam logic [3:0] S_HMUL = 4'd3;
    localparam logic [3:0] S_DRD  = 4'd4;
    localparam logic [3:0] S_DCMP = 4'd5;
    localparam logic [3:0] S_DEND = 4'd6;
    localparam logic [3:0] S_PRD  = 4'd7;
    localparam logic [3:0] S_PCMP = 4'd8;
    localparam logic [3:0] S_PEND = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.last_clr) begin
                    o_cmd.scan_clr = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.ptr_inc = 1'b1;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                o_cmd.scan_clr = 1'b1;
                case (i_sts.kind)
                    KIND_LOAD: begin
                        o_cmd.deny_wr = i_sts.slot_ok;
                        n_state = S_IDLE;
                    end
                    KIND_PATH: begin
                        if (!i_sts.byte_zero) begin
                            if (i_sts.count_full) begin
                                n_state = S_IDLE;
                            end else begin
                                o_cmd.hash_xor = 1'b1;
                                n_state = S_HMUL;
                            end
                        end else begin
                            n_state = S_DRD;
                        end
                    end
                    KIND_EXIT: n_state = S_PRD;
                    default: begin
                        n_state = i_sts.prior_zero ? S_PRD : S_OUT;
                    end
                endcase
            end
            S_HMUL: begin
                o_cmd.hash_mul = 1'b1;
                n_state = S_IDLE;
            end
            S_DRD: n_state = S_DCMP;
            S_DCMP: begin
                o_cmd.dcmp = 1'b1;
                if (i_sts.last_deny) begin
                    n_state = S_DEND;
                end else begin
                    o_cmd.ptr_inc = 1'b1;
                    n_state = S_DRD;
                end
            end
            S_DEND: begin
                if (i_sts.hit) begin
                    o_cmd.scan_clr = 1'b1;
                    n_state = S_PRD;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_PRD: n_state = S_PCMP;
            S_PCMP: begin
                o_cmd.pcmp = 1'b1;
                if (i_sts.last_pend) begin
                    n_state = S_PEND;
                end else begin
                    o_cmd.ptr_inc = 1'b1;
                    n_state = S_PRD;
                end
            end
            S_PEND: begin
                if (i_sts.kind == KIND_PATH) begin
                    o_cmd.pend_wr = !i_sts.found && i_sts.free;
                end else begin
                    o_cmd.pend_wr = i_sts.found;
                end
                n_state = (i_sts.kind == KIND_EXIT) ? S_IDLE : S_OUT;
            end
            S_OUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

>>> hdl/phdg_dp.sv
// ---------------------------------------------------------------------------
// phdg_dp
// Datapath: item capture, FNV-1a fold, deny and pending tables, result register.
// ---------------------------------------------------------------------------
module phdg_dp #(
    parameter int DENY_ENTRIES    = 32,
    parameter int PENDING_ENTRIES = 64,
    parameter int PATH_BYTES      = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  phdg_pkg::t_cmd        i_cmd,
    output phdg_pkg::t_sts        o_sts,
    input  logic [1:0]            i_kind,
    input  logic [4:0]            i_slot,
    input  logic [63:0]           i_entry_hash,
    input  logic                  i_entry_valid,
    input  logic [7:0]            i_path_byte,
    input  logic [63:0]           i_process_key,
    input  logic signed [12:0]    i_prior_result,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_result_kind,
    output logic [63:0]           o_path_hash,
    output logic                  o_denied_path,
    output logic                  o_table_full,
    output logic signed [12:0]    o_verdict
);
    import phdg_pkg::*;

    localparam int MAXD = (DENY_ENTRIES > PENDING_ENTRIES) ? DENY_ENTRIES : PENDING_ENTRIES;
    localparam int CW   = (MAXD > 1) ? $clog2(MAXD) : 1;
    localparam int DAW  = (DENY_ENTRIES > 1) ? $clog2(DENY_ENTRIES) : 1;
    localparam int PAW  = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;
    localparam int CNTW = $clog2(PATH_BYTES);

    logic [1:0]         r_kind;
    logic [4:0]         r_slot;
    logic [63:0]        r_ehash;
    logic               r_evalid;
    logic [7:0]         r_byte;
    logic [63:0]        r_key;
    logic [12:0]        r_prior;
    logic [63:0]        r_acc;
    logic [63:0]        r_mix;
    logic [CNTW-1:0]    r_cnt;
    logic [CW-1:0]      r_ptr;
    logic               r_hit;
    logic               r_found;
    logic               r_free;
    logic [PAW-1:0]     r_midx;
    logic [PAW-1:0]     r_fidx;
    logic               r_ovalid;
    logic               r_okind;
    logic [63:0]        r_ohash;
    logic               r_odeny;
    logic               r_ofull;
    logic [12:0]        r_overdict;

    logic               d_we;
    logic [DAW-1:0]     d_addr;
    logic [64:0]        d_wdata;
    logic [64:0]        d_rdata;
    logic               p_we;
    logic [PAW-1:0]     p_addr;
    logic [64:0]        p_wdata;
    logic [64:0]        p_rdata;
    logic [31:0]        slot_ext;
    logic               ptr_in_deny;
    logic               ptr_in_pend;

    assign slot_ext    = 32'(r_slot);
    assign ptr_in_deny = 32'(r_ptr) < 32'(DENY_ENTRIES);
    assign ptr_in_pend = 32'(r_ptr) < 32'(PENDING_ENTRIES);

    always_comb begin
        d_we    = (i_cmd.clr_wr && ptr_in_deny) || i_cmd.deny_wr;
        d_addr  = i_cmd.deny_wr ? slot_ext[DAW-1:0] : r_ptr[DAW-1:0];
        d_wdata = i_cmd.deny_wr ? {r_evalid, r_ehash} : '0;
        p_we    = (i_cmd.clr_wr && ptr_in_pend) || i_cmd.pend_wr;
        if (i_cmd.pend_wr) begin
            p_addr  = (r_kind == KIND_PATH) ? r_fidx : r_midx;
            p_wdata = (r_kind == KIND_PATH) ? {1'b1, r_key} : '0;
        end else begin
            p_addr  = r_ptr[PAW-1:0];
            p_wdata = '0;
        end
    end

    phdg_ram #(.WIDTH(65), .DEPTH(DENY_ENTRIES)) u_deny_ram (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_addr  (d_addr),
        .i_wdata (d_wdata),
        .o_rdata (d_rdata)
    );

    phdg_ram #(.WIDTH(65), .DEPTH(PENDING_ENTRIES)) u_pend_ram (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_addr  (p_addr),
        .i_wdata (p_wdata),
        .o_rdata (p_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_kind   <= i_kind;
            r_slot   <= i_slot;
            r_ehash  <= i_entry_hash;
            r_evalid <= i_entry_valid;
            r_byte   <= i_path_byte;
            r_key    <= i_process_key;
            r_prior  <= i_prior_result;
        end
        if (i_cmd.hash_xor) begin
            r_mix <= r_acc ^ {56'd0, r_byte};
        end
        if (i_cmd.pcmp) begin
            if (p_rdata[64] && p_rdata[63:0] == r_key && !r_found) begin
                r_midx <= r_ptr[PAW-1:0];
            end
            if (!p_rdata[64] && !r_free) begin
                r_fidx <= r_ptr[PAW-1:0];
            end
        end
        if (i_cmd.out_load) begin
            if (r_kind == KIND_PATH) begin
                r_okind    <= 1'b0;
                r_ohash    <= r_acc;
                r_odeny    <= r_hit;
                r_ofull    <= r_hit && !r_found && !r_free;
                r_overdict <= '0;
            end else begin
                r_okind <= 1'b1;
                r_ohash <= '0;
                r_odeny <= 1'b0;
                r_ofull <= 1'b0;
                if (r_prior != '0) begin
                    r_overdict <= r_prior;
                end else if (r_found) begin
                    r_overdict <= DENY_VERDICT;
                end else begin
                    r_overdict <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= FNV_BASIS;
            r_cnt    <= '0;
            r_ptr    <= '0;
            r_hit    <= 1'b0;
            r_found  <= 1'b0;
            r_free   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.hash_mul) begin
                r_acc <= fnv_mul(r_mix);
                r_cnt <= r_cnt + 1'b1;
            end else if (i_cmd.out_load && r_kind == KIND_PATH) begin
                r_acc <= FNV_BASIS;
                r_cnt <= '0;
            end
            if (i_cmd.scan_clr) begin
                r_ptr   <= '0;
                r_found <= 1'b0;
                r_free  <= 1'b0;
            end else if (i_cmd.ptr_inc) begin
                r_ptr <= r_ptr + 1'b1;
            end
            if (i_cmd.cap) begin
                r_hit <= 1'b0;
            end else if (i_cmd.dcmp && d_rdata[64] && d_rdata[63:0] == r_acc) begin
                r_hit <= 1'b1;
            end
            if (i_cmd.pcmp) begin
                if (p_rdata[64] && p_rdata[63:0] == r_key) begin
                    r_found <= 1'b1;
                end
                if (!p_rdata[64]) begin
                    r_free <= 1'b1;
                end
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.kind       = r_kind;
        o_sts.byte_zero  = (r_byte == 8'd0);
        o_sts.prior_zero = (r_prior == '0);
        o_sts.slot_ok    = slot_ext < 32'(DENY_ENTRIES);
        o_sts.count_full = (r_cnt == CNTW'(PATH_BYTES - 1));
        o_sts.last_deny  = (r_ptr == CW'(DENY_ENTRIES - 1));
        o_sts.last_pend  = (r_ptr == CW'(PENDING_ENTRIES - 1));
        o_sts.last_clr   = (r_ptr == CW'(MAXD - 1));
        o_sts.hit        = r_hit;
        o_sts.found      = r_found;
        o_sts.free       = r_free;
        o_sts.out_busy   = r_ovalid && !i_out_ready;
    end

    assign o_out_valid   = r_ovalid;
    assign o_result_kind = r_okind;
    assign o_path_hash   = r_ohash;
    assign o_denied_path = r_odeny;
    assign o_table_full  = r_ofull;
    assign o_verdict     = r_overdict;
endmodule

>>> hdl/path_hash_deny_gate.sv
// ---------------------------------------------------------------------------
// path_hash_deny_gate
// FNV-1a 64 path hashing with deny list match and pending open refusals.
// ---------------------------------------------------------------------------
//  channel  handshake                  payload
//  input    i_in_valid / o_in_ready    i_kind .. i_prior_result
//  output   o_out_valid / i_out_ready  o_result_kind .. o_verdict
//
//  Load: one deny slot write. Path byte: xor, then constant multiply.
//  Path end: deny table scan, plus a pending table scan on a match.
//  Open exit: pending table scan; open check: pending table scan, skipped with
//  a nonzero prior result. Each table entry is one RAM read and one compare.
//  A result waits in the output register; a stalled output holds the next result.
//  After reset a clearing pass over max(DENY_ENTRIES, PENDING_ENTRIES) entries runs first.
// ---------------------------------------------------------------------------
module path_hash_deny_gate #(
    parameter int DENY_ENTRIES    = 32,
    parameter int PENDING_ENTRIES = 64,
    parameter int PATH_BYTES      = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_kind,
    input  logic [4:0]         i_slot,
    input  logic [63:0]        i_entry_hash,
    input  logic               i_entry_valid,
    input  logic [7:0]         i_path_byte,
    input  logic [63:0]        i_process_key,
    input  logic signed [12:0] i_prior_result,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_result_kind,
    output logic [63:0]        o_path_hash,
    output logic               o_denied_path,
    output logic               o_table_full,
    output logic signed [12:0] o_verdict
);
    import phdg_pkg::*;

    t_cmd cmd;
    t_sts sts;

    phdg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    phdg_dp #(
        .DENY_ENTRIES    (DENY_ENTRIES),
        .PENDING_ENTRIES (PENDING_ENTRIES),
        .PATH_BYTES      (PATH_BYTES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_kind         (i_kind),
        .i_slot         (i_slot),
        .i_entry_hash   (i_entry_hash),
        .i_entry_valid  (i_entry_valid),
        .i_path_byte    (i_path_byte),
        .i_process_key  (i_process_key),
        .i_prior_result (i_prior_result),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result_kind  (o_result_kind),
        .o_path_hash    (o_path_hash),
        .o_denied_path  (o_denied_path),
        .o_table_full   (o_table_full),
        .o_verdict      (o_verdict)
    );
endmodule

>>> hdl/phdg_checker.sv
// ---------------------------------------------------------------------------
// phdg_checker
// Port-level checks for the path hash deny gate.
// ---------------------------------------------------------------------------
module phdg_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic               o_result_kind,
    input logic [63:0]        o_path_hash,
    input logic               o_denied_path,
    input logic               o_table_full,
    input logic signed [12:0] o_verdict
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_path_hash) && $stable(o_verdict))
        else $error("output beat changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second beat taken while busy");

    a_verdict_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_kind |->
            o_path_hash == 64'd0 && !o_denied_path && !o_table_full)
        else $error("open verdict carries path fields");

    a_path_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_result_kind |-> o_verdict == 13'sd0 &&
            (!o_table_full || o_denied_path))
        else $error("path result inconsistent");
endmodule

bind path_hash_deny_gate phdg_checker u_phdg_checker (.*);

>>> bench/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Testbench for path_hash_deny_gate. Drives deny loads, path bytes, open exits
// and open checks with random idling on both channels, predicts each path
// result and open verdict, and compares them field by field in arrival order.
// ---------------------------------------------------------------------------
module tb;
    import phdg_pkg::*;

    localparam int NUM_DENY  = 32;
    localparam int NUM_PEND  = 64;
    localparam int MAX_CHARS = 255;
    localparam logic [63:0] HASH_MUL = 64'd1099511628211;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic               result_kind;
        logic [63:0]        path_hash;
        logic               denied_path;
        logic               table_full;
        logic signed [12:0] verdict;
    } t_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [1:0]         i_kind;
    logic [4:0]         i_slot;
    logic [63:0]        i_entry_hash;
    logic               i_entry_valid;
    logic [7:0]         i_path_byte;
    logic [63:0]        i_process_key;
    logic signed [12:0] i_prior_result;
    logic               o_out_valid;
    logic               i_out_ready;
    logic               o_result_kind;
    logic [63:0]        o_path_hash;
    logic               o_denied_path;
    logic               o_table_full;
    logic signed [12:0] o_verdict;

    path_hash_deny_gate u_dut (.*);

    // predictor state
    logic [63:0] deny_hash_tbl [NUM_DENY];
    logic        deny_on       [NUM_DENY];
    logic [63:0] pend_key_tbl  [NUM_PEND];
    logic        pend_on       [NUM_PEND];
    logic [63:0] running_hash;
    int          chars_folded;

    t_result     expected_results [$];
    int          n_errors;
    int          n_beats_in;
    int          n_results;
    int          n_denied;
    int          n_full;
    int          n_refused;
    bit          idle_on;
    longint      cycles;
    logic [63:0] denied_hashes [$];
    logic [63:0] known_keys [$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycles);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    function automatic int find_key(input logic [63:0] key);
        for (int i = 0; i < NUM_PEND; i++)
            if (pend_on[i] && pend_key_tbl[i] == key) return i;
        return -1;
    endfunction

    function automatic void drop_key(input logic [63:0] key);
        int idx;
        idx = find_key(key);
        if (idx >= 0) begin
            pend_on[idx] = 1'b0;
            pend_key_tbl[idx] = '0;
        end
    endfunction

    // fold one item into the predicted state; queue its result if any
    function automatic void predict_gate(input logic [1:0] kind, input logic [4:0] slot,
                                         input logic [63:0] ehash, input logic evalid,
                                         input logic [7:0] pbyte, input logic [63:0] key,
                                         input logic [12:0] prior);
        t_result r;
        logic    hit;
        logic    full;
        int      free_idx;
        r = '0;
        case (kind)
            KIND_LOAD: begin
                deny_hash_tbl[slot] = ehash;
                deny_on[slot] = evalid;
            end
            KIND_PATH: begin
                if (pbyte != 0) begin
                    if (chars_folded < MAX_CHARS) begin
                        running_hash = (running_hash ^ {56'd0, pbyte}) * HASH_MUL;
                        chars_folded++;
                    end
                end else begin
                    hit = 1'b0;
                    full = 1'b0;
                    for (int i = 0; i < NUM_DENY; i++)
                        if (deny_on[i] && deny_hash_tbl[i] == running_hash) hit = 1'b1;
                    if (hit && find_key(key) < 0) begin
                        free_idx = -1;
                        for (int i = NUM_PEND - 1; i >= 0; i--)
                            if (!pend_on[i]) free_idx = i;
                        if (free_idx < 0) full = 1'b1;
                        else begin
                            pend_on[free_idx] = 1'b1;
                            pend_key_tbl[free_idx] = key;
                        end
                    end
                    r.path_hash = running_hash;
                    r.denied_path = hit;
                    r.table_full = full;
                    n_denied += hit;
                    n_full += full;
                    running_hash = FNV_BASIS;
                    chars_folded = 0;
                    expected_results.push_back(r);
                end
            end
            KIND_EXIT: drop_key(key);
            default: begin
                r.result_kind = 1'b1;
                if (prior != 0) r.verdict = prior;
                else if (find_key(key) >= 0) begin
                    drop_key(key);
                    r.verdict = DENY_VERDICT;
                    n_refused++;
                end
                expected_results.push_back(r);
            end
        endcase
    endfunction

    task automatic idle_burst();
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
    endtask

    task automatic send_item(input logic [1:0] kind, input logic [4:0] slot,
                             input logic [63:0] ehash, input logic evalid,
                             input logic [7:0] pbyte, input logic [63:0] key,
                             input logic [12:0] prior);
        idle_burst();
        i_in_valid     <= 1'b1;
        i_kind         <= kind;
        i_slot         <= slot;
        i_entry_hash   <= ehash;
        i_entry_valid  <= evalid;
        i_path_byte    <= pbyte;
        i_process_key  <= key;
        i_prior_result <= prior;
        do @(posedge i_clk); while (!o_in_ready);
        predict_gate(kind, slot, ehash, evalid, pbyte, key, prior);
        n_beats_in++;
        @(negedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] pick_key();
        if (known_keys.size() > 0 && $urandom_range(0, 3) != 0)
            return known_keys[$urandom_range(0, known_keys.size() - 1)];
        return rand64();
    endfunction

    function automatic logic [63:0] fnv_of(input logic [7:0] s [$]);
        logic [63:0] h;
        h = FNV_BASIS;
        foreach (s[i]) h = (h ^ {56'd0, s[i]}) * HASH_MUL;
        return h;
    endfunction

    task automatic send_path(input logic [7:0] s [$], input logic [63:0] key);
        foreach (s[i]) send_item(KIND_PATH, '0, rand64(), 1'b0, s[i], rand64(), '0);
        send_item(KIND_PATH, '0, rand64(), 1'b0, 8'd0, key, '0);
    endtask

    function automatic void rand_path(output logic [7:0] s [$], input int len);
        s = {};
        repeat (len) s.push_back(8'($urandom_range(1, 255)));
    endfunction

    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_results.size() > 0) @(negedge i_clk);
    endtask

    // sink: random stalls, check each beat against the oldest expectation
    initial begin
        t_result got;
        t_result exp_r;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (idle_on && $urandom_range(0, 7) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                got = '{o_result_kind, o_path_hash, o_denied_path, o_table_full, o_verdict};
                n_results++;
                if (expected_results.size() == 0) begin
                    $error("result with nothing expected");
                    n_errors++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got.result_kind !== exp_r.result_kind) begin
                        $error("result_kind exp %0d got %0d", exp_r.result_kind, got.result_kind);
                        n_errors++;
                    end
                    if (got.path_hash !== exp_r.path_hash) begin
                        $error("path_hash exp %h got %h", exp_r.path_hash, got.path_hash);
                        n_errors++;
                    end
                    if (got.denied_path !== exp_r.denied_path) begin
                        $error("denied_path exp %0d got %0d", exp_r.denied_path, got.denied_path);
                        n_errors++;
                    end
                    if (got.table_full !== exp_r.table_full) begin
                        $error("table_full exp %0d got %0d", exp_r.table_full, got.table_full);
                        n_errors++;
                    end
                    if (got.verdict !== exp_r.verdict) begin
                        $error("verdict exp %0d got %0d", exp_r.verdict, got.verdict);
                        n_errors++;
                    end
                end
            end
        end
    end

    task automatic load_deny(input logic [4:0] slot, input logic [63:0] h, input logic v);
        send_item(KIND_LOAD, slot, h, v, 8'($urandom()), rand64(), 13'($urandom()));
        if (v) denied_hashes.push_back(h);
    endtask

    task automatic test_directed();
        logic [7:0] s [$];
        logic [63:0] k;
        k = 64'hFFFF_FFFF_FFFF_FFFF;
        s = '{8'h2F, 8'h65, 8'h74, 8'h63};
        load_deny(5'd0, FNV_BASIS, 1'b1);
        load_deny(5'd31, fnv_of(s), 1'b1);
        load_deny(5'd7, fnv_of(s), 1'b1);
        load_deny(5'd3, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_path(s, k);
        send_path(s, k);
        send_item(KIND_CHECK, '0, '0, 1'b0, '0, k, 13'h1000);
        send_item(KIND_CHECK, '0, '0, 1'b0, '0, k, 13'h1FFF);
        send_item(KIND_CHECK, '0, '0, 1'b0, '0, k, '0);
        send_item(KIND_CHECK, '0, '0, 1'b0, '0, k, '0);
        s = {};
        send_path(s, 64'd0);
        send_item(KIND_EXIT, '0, '0, 1'b0, '0, 64'd0, '0);
        send_item(KIND_CHECK, '0, '0, 1'b0, '0, 64'd0, '0);
        send_item(KIND_EXIT, '0, '0, 1'b0, '0, 64'd99, '0);
        load_deny(5'd0, FNV_BASIS, 1'b0);
        send_path(s, 64'd5);
        drain();
    endtask

    task automatic test_long_path();
        logic [7:0] s [$];
        rand_path(s, MAX_CHARS);
        load_deny(5'd9, fnv_of(s), 1'b1);
        s.push_back(8'hFF);
        s.push_back(8'h01);
        send_path(s, 64'h1234);
        send_item(KIND_CHECK, '0, '0, 1'b0, '0, 64'h1234, '0);
        drain();
    endtask

    task automatic test_full_table();
        logic [7:0] s [$];
        s = '{8'h41};
        load_deny(5'd1, fnv_of(s), 1'b1);
        for (int i = 0; i < NUM_PEND + 2; i++) send_path(s, 64'(1000 + i));
        for (int i = 0; i < NUM_PEND; i += 2)
            send_item(KIND_EXIT, '0, '0, 1'b0, '0, 64'(1000 + i), '0);
        for (int i = 0; i < 4; i++) send_path(s, 64'(5000 + i));
        for (int i = 0; i < NUM_PEND + 4; i++)
            send_item(KIND_CHECK, '0, '0, 1'b0, '0, 64'(1000 + i), '0);
        for (int i = 0; i < 4; i++)
            send_item(KIND_EXIT, '0, '0, 1'b0, '0, 64'(5000 + i), '0);
        load_deny(5'd1, '0, 1'b0);
        drain();
    endtask

    task automatic test_random(input int n_items);
        logic [7:0] s [$];
        int done;
        done = 0;
        for (int i = 0; i < 8; i++) known_keys.push_back(rand64());
        while (done < n_items) begin
            case ($urandom_range(0, 9))
                0: begin
                    rand_path(s, $urandom_range(0, 6));
                    load_deny(5'($urandom()), $urandom_range(0, 1) ? fnv_of(s) : rand64(),
                              $urandom_range(0, 3) != 0);
                    done++;
                end
                1, 2, 3, 4: begin
                    if ($urandom_range(0, 1) && denied_hashes.size() > 0)
                        s = '{8'h2F, 8'h65, 8'h74, 8'h63};
                    else rand_path(s, $urandom_range(0, 8));
                    if ($urandom_range(0, 2) == 0 && s.size() > 0)
                        load_deny(5'($urandom()), fnv_of(s), 1'b1);
                    send_path(s, pick_key());
                    done += s.size() + 1;
                end
                5, 6: begin
                    send_item(KIND_EXIT, '0, '0, 1'b0, '0, pick_key(), '0);
                    done++;
                end
                default: begin
                    send_item(KIND_CHECK, '0, '0, 1'b0, '0, pick_key(),
                              $urandom_range(0, 2) == 0 ? 13'($urandom()) : 13'd0);
                    done++;
                end
            endcase
        end
        drain();
    endtask

    initial begin
        n_errors = 0;
        n_beats_in = 0;
        n_results = 0;
        n_denied = 0;
        n_full = 0;
        n_refused = 0;
        idle_on = 1'b1;
        running_hash = FNV_BASIS;
        chars_folded = 0;
        for (int i = 0; i < NUM_DENY; i++) begin
            deny_hash_tbl[i] = '0;
            deny_on[i] = 1'b0;
        end
        for (int i = 0; i < NUM_PEND; i++) begin
            pend_key_tbl[i] = '0;
            pend_on[i] = 1'b0;
        end
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_kind = KIND_LOAD;
        i_slot = '0;
        i_entry_hash = '0;
        i_entry_valid = 1'b0;
        i_path_byte = '0;
        i_process_key = '0;
        i_prior_result = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_long_path();
        test_full_table();
        test_random(130);
        idle_on = 1'b0;
        test_random(40);

        repeat (400) @(negedge i_clk);
        $display("sent %0d beats, checked %0d results", n_beats_in, n_results);
        $display("deny hits %0d, table full %0d, opens refused %0d",
                 n_denied, n_full, n_refused);
        if (n_errors == 0 && expected_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
